[sv/assert_macros.svh]
// assertion helpers, sampled on clk and disabled during rst
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

[sv/tsc_pkg.sv]
package tsc_pkg;

  localparam int TYPE_BITS  = 5;
  localparam int CODE_BITS  = 10;
  localparam int VALUE_BITS = 12;
  localparam int THR_BITS   = 10;
  localparam int OUT_BITS   = 12;
  localparam int IDX_BITS   = 2;

  localparam logic [TYPE_BITS-1:0] EVT_KEY = 5'd1;
  localparam logic [TYPE_BITS-1:0] EVT_ABS = 5'd3;

  localparam logic [CODE_BITS-1:0] CODE_X     = 10'd0;
  localparam logic [CODE_BITS-1:0] CODE_Y     = 10'd1;
  localparam logic [CODE_BITS-1:0] CODE_TOUCH = 10'd330;

  localparam logic [IDX_BITS-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [IDX_BITS-1:0] REG_SCALE_EN  = 2'd1;

  localparam logic [THR_BITS-1:0] THRESHOLD_RST = 10'd30;

  // x * 800 / 1024 == (x * 25) >> 5
  localparam int X_MUL   = 25;
  localparam int X_SHIFT = 5;
  // y * 480 / 600 == (4y) / 5, done as 4y * 52429 >> 18 (exact for 4y < 2^14)
  localparam int Y_PRE   = 2;
  localparam int Y_RECIP = 52429;
  localparam int Y_SHIFT = 18;

  typedef enum logic [2:0] {
    G_RIGHT = 3'd0,
    G_LEFT  = 3'd1,
    G_DOWN  = 3'd2,
    G_UP    = 3'd3,
    G_TAP   = 3'd4
  } gesture_t;

  typedef enum logic [1:0] {
    OP_X   = 2'd0,
    OP_Y   = 2'd1,
    OP_REL = 2'd2
  } op_kind_t;

endpackage

[sv/tsc_front.sv]
module tsc_front #(
  parameter int COORD_BITS = 12
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic [tsc_pkg::TYPE_BITS-1:0]   in_type,
  input  logic [tsc_pkg::CODE_BITS-1:0]   in_code,
  input  logic [tsc_pkg::VALUE_BITS-1:0]  in_value,
  input  logic                            scale_en,
  input  logic                            q_ready,
  output logic                            in_ready,
  output logic                            push,
  output tsc_pkg::op_kind_t               push_kind,
  output logic [COORD_BITS-1:0]           push_coord
);
  import tsc_pkg::*;

  logic                      is_x;
  logic                      is_y;
  logic                      is_rel;
  logic [VALUE_BITS+4:0]     x_prod;
  logic [VALUE_BITS+1:0]     y_quad;
  logic [VALUE_BITS+17:0]    y_prod;
  logic [VALUE_BITS-1:0]     x_scaled;
  logic [VALUE_BITS-1:0]     y_scaled;
  logic [VALUE_BITS-1:0]     coord_raw;
  logic [15:0]               coord_wide;

  assign is_x   = (in_type == EVT_ABS) && (in_code == CODE_X);
  assign is_y   = (in_type == EVT_ABS) && (in_code == CODE_Y);
  assign is_rel = (in_type == EVT_KEY) && (in_code == CODE_TOUCH) && (in_value == '0);

  assign x_prod   = (VALUE_BITS+5)'(in_value) * (VALUE_BITS+5)'(X_MUL);
  assign x_scaled = x_prod[X_SHIFT +: VALUE_BITS];

  assign y_quad   = (VALUE_BITS+2)'(in_value) << Y_PRE;
  assign y_prod   = (VALUE_BITS+18)'(y_quad) * (VALUE_BITS+18)'(Y_RECIP);
  assign y_scaled = y_prod[Y_SHIFT +: VALUE_BITS];

  always_comb begin
    if (!scale_en) begin
      coord_raw = in_value;
    end else if (is_y) begin
      coord_raw = y_scaled;
    end else begin
      coord_raw = x_scaled;
    end
  end

  // stored coordinates keep COORD_BITS bits
  assign coord_wide = 16'(coord_raw);
  assign push_coord = coord_wide[COORD_BITS-1:0];

  always_comb begin
    if (is_rel) begin
      push_kind = OP_REL;
    end else if (is_y) begin
      push_kind = OP_Y;
    end else begin
      push_kind = OP_X;
    end
  end

  // ignored events are dropped here and never reach the queue
  assign in_ready = q_ready;
  assign push     = in_valid && q_ready && (is_x || is_y || is_rel);

  `include "assert_macros.svh"

  `ASSERT_IMPL(a_push_known, push, is_x || is_y || is_rel)
  `ASSERT_IMPL(a_push_ready, push, in_ready && !rst)

endmodule

[sv/tsc_queue.sv]
module tsc_queue #(
  parameter int DW = 14
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  logic [DW-1:0] push_data,
  output logic          ready,
  input  logic          pop,
  output logic          valid,
  output logic [DW-1:0] pop_data
);
  import tsc_pkg::*;

  localparam int DEPTH = 2;

  logic [DW-1:0] slots [DEPTH];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;
  logic          do_push;
  logic          do_pop;

  assign ready    = (count != 2'(DEPTH)) || pop;
  assign valid    = (count != 2'd0);
  assign pop_data = slots[rd_ptr];
  assign do_push  = push && ready;
  assign do_pop   = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

  `include "assert_macros.svh"

  `ASSERT_IMPL(a_no_overflow, count == 2'(DEPTH) && !pop, !do_push)

endmodule

[sv/tsc_back.sv]
module tsc_back #(
  parameter int COORD_BITS = 12
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           q_valid,
  input  tsc_pkg::op_kind_t              q_kind,
  input  logic [COORD_BITS-1:0]          q_coord,
  output logic                           q_pop,
  input  logic [tsc_pkg::THR_BITS-1:0]   threshold,
  output logic                           out_valid,
  input  logic                           out_ready,
  output tsc_pkg::gesture_t              out_gesture,
  output logic [tsc_pkg::OUT_BITS-1:0]   out_x,
  output logic [tsc_pkg::OUT_BITS-1:0]   out_y
);
  import tsc_pkg::*;

  localparam int W = COORD_BITS + 3;

  logic [COORD_BITS-1:0] start_x;
  logic [COORD_BITS-1:0] start_y;
  logic [COORD_BITS-1:0] current_x;
  logic [COORD_BITS-1:0] current_y;
  logic                  seen_x;
  logic                  seen_y;
  // running deltas, zero while an axis is untouched
  logic signed [W-1:0]   dx;
  logic signed [W-1:0]   dy;

  logic signed [W-1:0]   coord_s;
  logic signed [W-1:0]   ax;
  logic signed [W-1:0]   ay;
  logic signed [W-1:0]   thr_s;
  logic signed [W-1:0]   thr_n;
  gesture_t              gesture_next;
  logic [15:0]           x_wide;
  logic [15:0]           y_wide;
  logic                  is_rel;

  assign is_rel = (q_kind == OP_REL);
  assign q_pop  = q_valid && (!is_rel || !out_valid || out_ready);

  assign coord_s = signed'(W'(q_coord));

  always_ff @(posedge clk) begin
    if (rst) begin
      start_x   <= '0;
      start_y   <= '0;
      current_x <= '0;
      current_y <= '0;
      seen_x    <= 1'b0;
      seen_y    <= 1'b0;
      dx        <= '0;
      dy        <= '0;
    end else if (q_pop) begin
      case (q_kind)
        OP_X: begin
          current_x <= q_coord;
          if (!seen_x) begin
            start_x <= q_coord;
            seen_x  <= 1'b1;
            dx      <= '0;
          end else begin
            dx <= coord_s - signed'(W'(start_x));
          end
        end
        OP_Y: begin
          current_y <= q_coord;
          if (!seen_y) begin
            start_y <= q_coord;
            seen_y  <= 1'b1;
            dy      <= '0;
          end else begin
            dy <= coord_s - signed'(W'(start_y));
          end
        end
        OP_REL: begin
          seen_x <= 1'b0;
          seen_y <= 1'b0;
          dx     <= '0;
          dy     <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  assign ax    = (dx < 0) ? -dx : dx;
  assign ay    = (dy < 0) ? -dy : dy;
  assign thr_s = signed'(W'(threshold));
  assign thr_n = -thr_s;

  always_comb begin
    if (dx > thr_s && ax > (ay <<< 1)) begin
      gesture_next = G_RIGHT;
    end else if (dx < thr_n && ax > (ay <<< 1)) begin
      gesture_next = G_LEFT;
    end else if (dy > thr_s && ay > (ax <<< 1)) begin
      gesture_next = G_DOWN;
    end else if (dy < thr_n && ay > (ax <<< 1)) begin
      gesture_next = G_UP;
    end else begin
      gesture_next = G_TAP;
    end
  end

  assign x_wide = 16'(current_x);
  assign y_wide = 16'(current_y);

  always_ff @(posedge clk) begin
    if (q_pop && is_rel) begin
      out_gesture <= gesture_next;
      out_x       <= x_wide[OUT_BITS-1:0];
      out_y       <= y_wide[OUT_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop && is_rel) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  `include "assert_macros.svh"

  `ASSERT_NEXT(a_rel_result, q_pop && is_rel, out_valid)
  `ASSERT_NEXT(a_rel_clears, q_pop && is_rel, dx == '0 && dy == '0 && !seen_x && !seen_y)
  `ASSERT_IMPL(a_untouched_zero, !seen_x || !seen_y, (seen_x || dx == '0) && (seen_y || dy == '0))

endmodule

[sv/touch_swipe_classifier_unit.sv]
// Touch swipe classifier: takes touch events (type on s_tuser, code and value on s_tdata)
// at up to one per cycle and gives one result on each touch release: a gesture code
// (0 right, 1 left, 2 down, 3 up, 4 tap) with the latest x and y. X and Y axis events are
// scaled to an 800 by 480 screen when scale_enable is set, else kept raw. An event is
// decoded and scaled as it is accepted, waits in a two-entry queue and updates the gesture
// state in the next stage; a release goes through the queue and the output register to
// m_tvalid. These let input and output stall independently; the sustained rate is one
// event per cycle while m_tready is high. Config writes (index 0 swipe_threshold, index 1
// scale_enable) are always ready and are meant to come while no event is in flight.
module touch_swipe_classifier_unit #(
  parameter int COORD_BITS = 12
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [4:0]  s_tuser,   // event_type
  input  logic [23:0] s_tdata,   // event_code[9:0], event_value[21:10], zero fill
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // gesture[2:0], touch_x[14:3], touch_y[26:15], zero fill
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [tsc_pkg::IDX_BITS-1:0] cfg_index,
  input  logic [tsc_pkg::THR_BITS-1:0] cfg_data
);
  import tsc_pkg::*;

  localparam int QW = COORD_BITS + 2;

  logic [THR_BITS-1:0]   swipe_threshold;
  logic                  scale_enable;

  logic                  q_ready;
  logic                  push;
  op_kind_t              push_kind;
  logic [COORD_BITS-1:0] push_coord;
  logic                  q_valid;
  logic                  q_pop;
  logic [QW-1:0]         q_data;
  op_kind_t              q_kind;
  logic [COORD_BITS-1:0] q_coord;
  gesture_t              out_gesture;
  logic [OUT_BITS-1:0]   out_x;
  logic [OUT_BITS-1:0]   out_y;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      swipe_threshold <= THRESHOLD_RST;
      scale_enable    <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_THRESHOLD: swipe_threshold <= cfg_data;
        REG_SCALE_EN:  scale_enable    <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  tsc_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_type    (s_tuser),
    .in_code    (s_tdata[9:0]),
    .in_value   (s_tdata[21:10]),
    .scale_en   (scale_enable),
    .q_ready    (q_ready),
    .in_ready   (s_tready),
    .push       (push),
    .push_kind  (push_kind),
    .push_coord (push_coord)
  );

  tsc_queue #(.DW(QW)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({push_kind, push_coord}),
    .ready     (q_ready),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_data  (q_data)
  );

  assign q_kind  = op_kind_t'(q_data[QW-1 -: 2]);
  assign q_coord = q_data[COORD_BITS-1:0];

  tsc_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_kind      (q_kind),
    .q_coord     (q_coord),
    .q_pop       (q_pop),
    .threshold   (swipe_threshold),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_gesture (out_gesture),
    .out_x       (out_x),
    .out_y       (out_y)
  );

  assign m_tdata = {5'd0, out_y, out_x, out_gesture};

endmodule
